// File: hdl/ftm_pkg.sv
package ftm_pkg;
  localparam int unsigned FRAC_W = 23;
  localparam int unsigned MANT_W = 24;
  localparam int unsigned EXP_W = 8;
  localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

  typedef struct packed {
    logic             sign;
    logic [EXP_W-1:0] exp_sum;
  } ftm_meta_t;
endpackage

// File: hdl/float32_truncating_multiplier_unit.sv
// Channel | Ports                                | Role
// in      | in_valid, in_ready, in_operand_a/b   | factor pair
// out     | out_valid, out_ready, out_product    | product word
// A chain of two 12x24 multiply cells takes one word per cycle unless the output stalls.
// The chain advances whenever its last cell is empty or the output takes its word.
// Reset clears the valid bits of both cells; payload registers are not reset.
// A stalled output holds the whole chain.
module float32_truncating_multiplier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_product
);
  import ftm_pkg::*;

  logic        adv;
  logic [23:0] ma, mb;
  ftm_meta_t   m0, m1, m2;
  logic        v1, v2;
  logic [11:0] ahi1, ahi2;
  logic [23:0] b1, b2;
  logic [47:0] acc1, acc2;
  logic [24:0] prod;
  logic        carry;
  logic [7:0]  exp_f;

  assign adv      = !v2 || out_ready;
  assign in_ready = adv;

  assign ma = {1'b1, in_operand_a[22:0]};
  assign mb = {1'b1, in_operand_b[22:0]};
  assign m0.sign    = in_operand_a[31] ^ in_operand_b[31];
  assign m0.exp_sum = in_operand_a[30:23] + in_operand_b[30:23] - EXP_BIAS;

  ftm_cell u_c0 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(in_valid), .meta_in(m0),
    .a_hi_in(ma[23:12]), .b_in(mb), .acc_in(48'd0), .a_slice(ma[11:0]),
    .shift(5'd0), .vld_out(v1), .meta_out(m1), .a_hi_out(ahi1), .b_out(b1),
    .acc_out(acc1)
  );

  ftm_cell u_c1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .vld_in(v1), .meta_in(m1),
    .a_hi_in(ahi1), .b_in(b1), .acc_in(acc1), .a_slice(ahi1),
    .shift(5'd12), .vld_out(v2), .meta_out(m2), .a_hi_out(ahi2), .b_out(b2),
    .acc_out(acc2)
  );

  assign prod  = acc2[47:23];
  assign carry = prod[24];
  assign exp_f = m2.exp_sum + 8'(carry);

  assign out_valid   = v2;
  assign out_product = {m2.sign, exp_f, carry ? prod[23:1] : prod[22:0]};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product))
    else $error("stalled product changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("chain stalled while empty at output");
  a_lead_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> acc2[47] || acc2[46])
    else $error("mantissa product lost its leading one");
endmodule

// File: hdl/ftm_cell.sv
module ftm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_in,
  input  ftm_pkg::ftm_meta_t   meta_in,
  input  logic [11:0]          a_hi_in,
  input  logic [23:0]          b_in,
  input  logic [47:0]          acc_in,
  input  logic [11:0]          a_slice,
  input  logic [4:0]           shift,
  output logic                 vld_out,
  output ftm_pkg::ftm_meta_t   meta_out,
  output logic [11:0]          a_hi_out,
  output logic [23:0]          b_out,
  output logic [47:0]          acc_out
);
  import ftm_pkg::*;

  logic [35:0] part;
  logic [47:0] acc_nxt;
  logic        vld_r;
  ftm_meta_t   meta_r;
  logic [11:0] a_hi_r;
  logic [23:0] b_r;
  logic [47:0] acc_r;

  // one 12x24 partial product per cell
  assign part    = a_slice * b_in;
  assign acc_nxt = acc_in + (48'(part) << shift);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r <= meta_in;
      a_hi_r <= a_hi_in;
      b_r    <= b_in;
      acc_r  <= acc_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign meta_out = meta_r;
  assign a_hi_out = a_hi_r;
  assign b_out    = b_r;
  assign acc_out  = acc_r;
endmodule
